>>> design/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
package mexp_pkg;

    localparam int OPERAND_WIDTH   = 16;
    localparam int CNT_WIDTH       = $clog2(OPERAND_WIDTH);
    localparam int SUM_WIDTH       = OPERAND_WIDTH + 2;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = CFG_INDEX_WIDTH'(1);

    localparam logic [OPERAND_WIDTH-1:0] EXPONENT_RESET = OPERAND_WIDTH'(1);
    localparam logic [OPERAND_WIDTH-1:0] MODULUS_RESET  = {OPERAND_WIDTH{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CHECK,
        ST_MULT,
        ST_SQUARE,
        ST_DONE
    } state_t;

endpackage

>>> design/rsa_modular_exponentiation_top.sv
// Modular exponentiation top level: sequencer around one shared modular multiplier.
//
// Usage: write the exponent (index 0) and modulus (index 1) on the cfg_ channel
// while the block is idle; cfg_ready is always high. Each request on the s_
// channel carries one base value and yields one result on the m_ channel:
// base_value ^ exponent mod modulus.
// A modular multiply runs on an interleaved shift-add-reduce unit (one
// multiplier bit per cycle, two conditional subtracts of the modulus). A request
// first reduces the base with one multiply, then for each exponent bit up to the
// highest set one multiplies if the bit is set and then squares, and finishes
// by handing the result to the output register.
// s_ready is high only while the sequencer is idle, one request at a time, so
// a new request is taken only once the current one has finished.
// The result sits in an output register; a new request is taken while an
// earlier result still waits, and the sequencer holds its finished result
// until the output register frees up when m_ready stays low.
// Reset (aresetn low, synchronous) clears the sequencer and the output valid
// and loads exponent 1 and modulus all ones.
module rsa_modular_exponentiation_top
    import mexp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [OPERAND_WIDTH-1:0]   cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OPERAND_WIDTH-1:0]   s_base_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [OPERAND_WIDTH-1:0]   m_result_value
);

    state_t                   state_reg, state_next;
    logic [OPERAND_WIDTH-1:0] exponent_reg;
    logic [OPERAND_WIDTH-1:0] modulus_reg;
    logic [OPERAND_WIDTH-1:0] exp_reg, exp_next;
    logic [OPERAND_WIDTH-1:0] acc_reg, acc_next;
    logic [OPERAND_WIDTH-1:0] sq_reg, sq_next;
    logic [OPERAND_WIDTH-1:0] op_a_reg, op_a_next;
    logic [OPERAND_WIDTH-1:0] op_b_reg, op_b_next;
    logic [OPERAND_WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_WIDTH-1:0]     cnt_reg, cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OPERAND_WIDTH-1:0] out_data_reg, out_data_next;

    logic [SUM_WIDTH-1:0]     sum;
    logic [SUM_WIDTH-1:0]     mod_ext;
    logic [SUM_WIDTH-1:0]     sub1;
    logic [SUM_WIDTH-1:0]     sub2;
    logic [OPERAND_WIDTH-1:0] step_rem;
    logic                     step_last;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = out_valid_reg;
    assign m_result_value = out_data_reg;

    // one step of interleaved modular multiplication
    always_comb begin
        mod_ext   = {2'b00, modulus_reg};
        sum       = {1'b0, rem_reg, 1'b0}
                  + (op_a_reg[OPERAND_WIDTH-1] ? {2'b00, op_b_reg} : '0);
        sub1      = (sum >= mod_ext) ? (sum - mod_ext) : sum;
        sub2      = (sub1 >= mod_ext) ? (sub1 - mod_ext) : sub1;
        step_rem  = sub2[OPERAND_WIDTH-1:0];
        step_last = (cnt_reg == CNT_WIDTH'(OPERAND_WIDTH - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exponent_reg <= EXPONENT_RESET;
            modulus_reg  <= MODULUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_EXPONENT: exponent_reg <= cfg_data;
                REG_MODULUS:  modulus_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        exp_reg      <= exp_next;
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        op_a_reg     <= op_a_next;
        op_b_reg     <= op_b_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        out_data_reg <= out_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_a_next  = s_base_value;
                    op_b_next  = OPERAND_WIDTH'(1);
                    rem_next   = '0;
                    cnt_next   = '0;
                    exp_next   = exponent_reg;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD, ST_MULT, ST_SQUARE: begin
                // advance the shared unit by one multiplier bit
                rem_next  = step_rem;
                op_a_next = {op_a_reg[OPERAND_WIDTH-2:0], 1'b0};
                cnt_next  = cnt_reg + CNT_WIDTH'(1);
                if (step_last) begin
                    rem_next = '0;
                    cnt_next = '0;
                    case (state_reg)
                        ST_LOAD: begin
                            sq_next    = step_rem;
                            acc_next   = OPERAND_WIDTH'(1);
                            state_next = ST_CHECK;
                        end
                        ST_MULT: begin
                            acc_next   = step_rem;
                            op_a_next  = sq_reg;
                            op_b_next  = sq_reg;
                            state_next = ST_SQUARE;
                        end
                        default: begin
                            sq_next    = step_rem;
                            exp_next   = {1'b0, exp_reg[OPERAND_WIDTH-1:1]};
                            state_next = ST_CHECK;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (exp_reg == '0) begin
                    state_next = ST_DONE;
                end else if (exp_reg[0]) begin
                    op_a_next  = acc_reg;
                    op_b_next  = sq_reg;
                    state_next = ST_MULT;
                end else begin
                    op_a_next  = sq_reg;
                    op_b_next  = sq_reg;
                    state_next = ST_SQUARE;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = (modulus_reg < OPERAND_WIDTH'(2)) ? '0 : acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> tb/rsa_modular_exponentiation_top_tb.sv
// Self-checking testbench for the modular exponentiation block: keyed phases of directed and random bases.
module rsa_modular_exponentiation_top_tb
    import mexp_pkg::*;
();

    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_EXPONENT;
    logic [OPERAND_WIDTH-1:0]   cfg_data = '0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [OPERAND_WIDTH-1:0]   s_base_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [OPERAND_WIDTH-1:0]   m_result_value;

    logic [OPERAND_WIDTH-1:0] pending_bases[$];
    logic [OPERAND_WIDTH-1:0] expected_results[$];
    logic [OPERAND_WIDTH-1:0] key_exponent = EXPONENT_RESET;
    logic [OPERAND_WIDTH-1:0] key_modulus = MODULUS_RESET;
    bit                       steady_flow = 1'b0;
    int                       mismatch_count = 0;
    int                       results_seen = 0;
    int                       send_gap = 0;
    int                       ready_gap = 0;
    int                       hold_left = 0;
    int                       idle_cycles = 0;

    rsa_modular_exponentiation_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_base_value   (s_base_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value)
    );

    always #1 aclk = ~aclk;

    function automatic logic [OPERAND_WIDTH-1:0] mod_power(
        input logic [OPERAND_WIDTH-1:0] base_val,
        input logic [OPERAND_WIDTH-1:0] exp_val,
        input logic [OPERAND_WIDTH-1:0] mod_val
    );
        logic [2*OPERAND_WIDTH-1:0] acc;
        logic [2*OPERAND_WIDTH-1:0] sq;
        logic [2*OPERAND_WIDTH-1:0] m_wide;
        if (mod_val == '0)
            return '0;
        m_wide = {{OPERAND_WIDTH{1'b0}}, mod_val};
        acc = 1 % m_wide;
        sq = {{OPERAND_WIDTH{1'b0}}, base_val} % m_wide;
        for (int i = 0; i < OPERAND_WIDTH; i++) begin
            if (exp_val[i])
                acc = (acc * sq) % m_wide;
            sq = (sq * sq) % m_wide;
        end
        return acc[OPERAND_WIDTH-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function automatic logic [OPERAND_WIDTH-1:0] pick_base(
        input logic [OPERAND_WIDTH-1:0] mod_val
    );
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return OPERAND_WIDTH'($urandom_range(0, 65535));
        if (r < 9)
            return OPERAND_WIDTH'($urandom_range(0, int'(mod_val) - 1));
        case ($urandom_range(0, 3))
            0: return '0;
            1: return OPERAND_WIDTH'(1);
            2: return mod_val - 1'b1;
            default: return '1;
        endcase
    endfunction

    // request side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready)
                expected_results = {expected_results,
                                    mod_power(s_base_value, key_exponent, key_modulus)};
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_bases.size() != 0) begin
                    s_valid <= 1'b1;
                    s_base_value <= pending_bases.pop_front();
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        logic [OPERAND_WIDTH-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_gap = 0;
            hold_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result_value %0d, expected none", $time,
                             m_result_value);
                end else begin
                    want = expected_results.pop_front();
                    if (m_result_value !== want) begin
                        mismatch_count++;
                        $display("%0t: result_value mismatch, expected %0d, actual %0d",
                                 $time, want, m_result_value);
                    end
                end
                results_seen++;
                if (results_seen == 120 || results_seen == 400)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                ready_gap = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[rsa_modular_exponentiation_top] ERROR");
            $finish;
        end
    end

    task automatic load_key(input logic [OPERAND_WIDTH-1:0] exp_val,
                            input logic [OPERAND_WIDTH-1:0] mod_val);
        cfg_valid <= 1'b1;
        cfg_index <= REG_EXPONENT;
        cfg_data <= exp_val;
        do @(posedge aclk); while (!cfg_ready);
        key_exponent = exp_val;
        cfg_index <= REG_MODULUS;
        cfg_data <= mod_val;
        do @(posedge aclk); while (!cfg_ready);
        key_modulus = mod_val;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        do @(negedge aclk);
        while (pending_bases.size() != 0 || s_valid || expected_results.size() != 0);
        @(posedge aclk);
    endtask

    initial begin
        int sent;
        int count;
        int r;
        logic [OPERAND_WIDTH-1:0] exp_val;
        logic [OPERAND_WIDTH-1:0] mod_val;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset key
        pending_bases = '{16'd0, 16'd1, 16'hFFFF, 16'hFFFE, 16'd12345};
        wait_drain();

        steady_flow = 1'b1;
        load_key(16'd0, 16'hFFFF);
        pending_bases = '{16'd0, 16'hFFFF, 16'd7};
        wait_drain();
        steady_flow = 1'b0;

        load_key(16'hFFFF, 16'd2);
        pending_bases = '{16'd0, 16'd1, 16'hFFFF, 16'd3};
        wait_drain();

        load_key(16'd17, 16'd3233);
        pending_bases = '{16'd65, 16'd3232, 16'd3233, 16'hFFFF};
        wait_drain();

        load_key(16'd2753, 16'd3233);
        pending_bases = '{16'd2790, 16'd0};
        wait_drain();

        // degenerate moduli
        load_key(16'd3, 16'd1);
        pending_bases = '{16'd5, 16'd0};
        wait_drain();

        load_key(16'd5, 16'd0);
        pending_bases = '{16'd9, 16'hFFFF};
        wait_drain();

        sent = 0;
        while (sent < 628) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                mod_val = OPERAND_WIDTH'($urandom_range(2, 65535));
            else if (r < 8)
                mod_val = OPERAND_WIDTH'($urandom_range(2, 255));
            else if (r == 8)
                mod_val = '1;
            else
                mod_val = OPERAND_WIDTH'(2);
            r = $urandom_range(0, 9);
            if (r < 6)
                exp_val = OPERAND_WIDTH'($urandom_range(0, 65535));
            else if (r < 8)
                exp_val = OPERAND_WIDTH'($urandom_range(0, 31));
            else if (r == 8)
                exp_val = '1;
            else
                exp_val = '0;
            steady_flow = ($urandom_range(0, 3) == 0);
            load_key(exp_val, mod_val);
            count = $urandom_range(20, 60);
            if (count > 628 - sent)
                count = 628 - sent;
            repeat (count)
                pending_bases = {pending_bases, pick_base(mod_val)};
            sent += count;
            wait_drain();
        end

        repeat (600) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[rsa_modular_exponentiation_top] OK");
        else
            $display("[rsa_modular_exponentiation_top] ERROR");
        $finish;
    end

endmodule
